### rtl/tms_pkg.sv
// Shared types, constants and helpers of the triangle midpoint subdivider.
// Used by the controller, the datapath and the top level; depends on nothing.
package tms_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int VERTS_PER_TRI   = 6;
    localparam int IDX_W           = 32;
    localparam int RADIUS_W        = 31;
    localparam int ROOT_STEPS      = 32;
    localparam int DIV_STEPS       = 32;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_EDGE   = 10'b00_0000_0010,
        ST_NORM   = 10'b00_0000_0100,
        ST_SQUARE = 10'b00_0000_1000,
        ST_ROOT   = 10'b00_0001_0000,
        ST_MUL    = 10'b00_0010_0000,
        ST_PREP   = 10'b00_0100_0000,
        ST_DIVIDE = 10'b00_1000_0000,
        ST_STORE  = 10'b01_0000_0000,
        ST_EMIT   = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic       load;
        logic       edge_load;
        logic [1:0] edge_sel;
        logic       norm_shift;
        logic       sq_acc;
        logic [1:0] axis;
        logic       root_step;
        logic       mul;
        logic       prep;
        logic       div_step;
        logic       store;
        logic       emit_load;
        logic [2:0] step;
        logic       advance;
    } cmd_t;

    typedef struct packed {
        logic norm_ok;
    } status_t;

    // Corner offset k of the new triangle emitted with result slot step.
    function automatic logic [2:0] tri_corner(input logic [2:0] step, input logic [1:0] k);
        logic [8:0] row;
        begin
            case (step)
                3'd0:    row = {3'd0, 3'd1, 3'd2};
                3'd1:    row = {3'd1, 3'd3, 3'd4};
                3'd2:    row = {3'd1, 3'd4, 3'd2};
                3'd3:    row = {3'd4, 3'd5, 3'd2};
                default: row = 9'd0;
            endcase
            case (k)
                2'd0:    tri_corner = row[8:6];
                2'd1:    tri_corner = row[5:3];
                default: tri_corner = row[2:0];
            endcase
        end
    endfunction

endpackage

### rtl/tms_if.sv
// Valid/ready channel interfaces for the triangle input and the vertex output.
// Depends on nothing; COORD_WIDTH sets the coordinate width.
interface tms_in_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;
    logic                          pass_start;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    third_x, third_y, third_z, pass_start, input ready);
    modport sink   (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    third_x, third_y, third_z, pass_start, output ready);
endinterface

interface tms_out_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic [31:0]                   vertex_number;
    logic                          tri_valid;
    logic [31:0]                   tri_a;
    logic [31:0]                   tri_b;
    logic [31:0]                   tri_c;
    logic                          last;

    modport source (output valid, out_x, out_y, out_z, vertex_number, tri_valid, tri_a, tri_b,
                    tri_c, last, input ready);
    modport sink   (input valid, out_x, out_y, out_z, vertex_number, tri_valid, tri_a, tri_b,
                    tri_c, last, output ready);
endinterface

### rtl/triangle_midpoint_subdivider_top.sv
// Top level of the triangle midpoint subdivider.
// Depends on tms_pkg, tms_if, tms_ctrl and tms_datapath.
//
// Usage:
//   tri_in carries one triangle per item (three signed Q16.16 corners and
//   pass_start). vtx_out carries six vertex items per triangle in the order
//   v1, m12, m13, v2, m23, v3; the first four also carry a new triangle,
//   the sixth has last set. radius_we/radius_wdata write the sphere radius
//   (unsigned Q15.16); write it only while the block is idle.
//   One triangle is in flight at a time: tri_in.ready is high only when idle.
//   Per midpoint the shared unit loads the edge sum, makes up to COORD_WIDTH-31
//   normalize shifts, square-accumulates the three axes, takes 32 square-root
//   steps and, per axis, does a multiply, a 32-step division and a store.
//   The six vertex items then leave at one item per cycle if the receiver
//   keeps ready high, and the block returns to idle.
//   The square-root and division iterations dominate the work per triangle.
//   Reset clears the vertex index, sets the radius to 1.0 and returns to idle.
//   A stalled receiver holds the current vertex item steady on vtx_out.
module triangle_midpoint_subdivider_top #(
    parameter int COORD_WIDTH = tms_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tms_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tms_in_if.sink                       tri_in,
    tms_out_if.source                    vtx_out,
    input  logic                         radius_we,
    input  logic [tms_pkg::RADIUS_W-1:0] radius_wdata
);
    import tms_pkg::*;

    cmd_t    cmd;
    status_t status;

    tms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tri_in.valid),
        .in_ready  (tri_in.ready),
        .out_valid (vtx_out.valid),
        .out_ready (vtx_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tms_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .radius_we     (radius_we),
        .radius_wdata  (radius_wdata),
        .in_first_x    (tri_in.first_x),
        .in_first_y    (tri_in.first_y),
        .in_first_z    (tri_in.first_z),
        .in_second_x   (tri_in.second_x),
        .in_second_y   (tri_in.second_y),
        .in_second_z   (tri_in.second_z),
        .in_third_x    (tri_in.third_x),
        .in_third_y    (tri_in.third_y),
        .in_third_z    (tri_in.third_z),
        .in_pass_start (tri_in.pass_start),
        .out_x         (vtx_out.out_x),
        .out_y         (vtx_out.out_y),
        .out_z         (vtx_out.out_z),
        .vertex_number (vtx_out.vertex_number),
        .tri_valid     (vtx_out.tri_valid),
        .tri_a         (vtx_out.tri_a),
        .tri_b         (vtx_out.tri_b),
        .tri_c         (vtx_out.tri_c),
        .last          (vtx_out.last)
    );

endmodule

### rtl/tms_ctrl.sv
// Sequencer of the subdivider: walks edges, axes and the iterative steps.
// Depends on tms_pkg; drives the datapath through cmd_t, reads status_t.
module tms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  tms_pkg::status_t status,
    output tms_pkg::cmd_t    cmd
);
    import tms_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] edge_reg, edge_next;
    logic [1:0] axis_reg, axis_next;
    logic [4:0] iter_reg, iter_next;
    logic [2:0] step_reg, step_next;

    localparam logic [4:0] ROOT_LAST = 5'(ROOT_STEPS - 1);
    localparam logic [4:0] DIV_LAST  = 5'(DIV_STEPS - 1);
    localparam logic [2:0] STEP_LAST = 3'(VERTS_PER_TRI - 1);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next = state_reg;
        edge_next  = edge_reg;
        axis_next  = axis_reg;
        iter_next  = iter_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.edge_sel = edge_reg;
        cmd.axis     = axis_reg;
        cmd.step     = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    edge_next  = 2'd0;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                cmd.edge_load = 1'b1;
                state_next    = ST_NORM;
            end
            ST_NORM:
            begin
                if (status.norm_ok)
                begin
                    axis_next  = 2'd0;
                    state_next = ST_SQUARE;
                end
                else
                begin
                    cmd.norm_shift = 1'b1;
                end
            end
            ST_SQUARE:
            begin
                cmd.sq_acc = 1'b1;
                if (axis_reg == 2'd2)
                begin
                    iter_next  = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                iter_next     = iter_reg + 5'd1;
                if (iter_reg == ROOT_LAST)
                begin
                    axis_next  = 2'd0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                iter_next  = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 5'd1;
                if (iter_reg == DIV_LAST)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (axis_reg != 2'd2)
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_MUL;
                end
                else if (edge_reg != 2'd2)
                begin
                    edge_next  = edge_reg + 2'd1;
                    state_next = ST_EDGE;
                end
                else
                begin
                    cmd.emit_load = 1'b1;
                    cmd.step      = 3'd0;
                    step_next     = 3'd0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_load = 1'b1;
                        cmd.step      = step_reg + 3'd1;
                        step_next     = step_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            edge_reg  <= '0;
            axis_reg  <= '0;
            iter_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            axis_reg  <= axis_next;
            iter_reg  <= iter_next;
            step_reg  <= step_next;
        end
    end

    a_accept_starts_edge: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_EDGE && edge_reg == 2'd0)
        else $error("accepted item did not start the first edge");

    a_stall_holds_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(step_reg))
        else $error("result slot moved while the receiver stalled");

    a_divide_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE && iter_reg == DIV_LAST |=> state_reg == ST_STORE)
        else $error("division did not finish after its last step");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && step_reg == STEP_LAST |=> in_ready)
        else $error("block not idle after the final result");

endmodule

### rtl/tms_datapath.sv
// Datapath: corner store, midpoint projection (normalize, square, root, divide)
// and the output register. Depends on tms_pkg; commanded by tms_ctrl.
module tms_datapath #(
    parameter int COORD_WIDTH = tms_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tms_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tms_pkg::cmd_t                 cmd,
    output tms_pkg::status_t              status,
    input  logic                          radius_we,
    input  logic [tms_pkg::RADIUS_W-1:0]  radius_wdata,
    input  logic signed [COORD_WIDTH-1:0] in_first_x,
    input  logic signed [COORD_WIDTH-1:0] in_first_y,
    input  logic signed [COORD_WIDTH-1:0] in_first_z,
    input  logic signed [COORD_WIDTH-1:0] in_second_x,
    input  logic signed [COORD_WIDTH-1:0] in_second_y,
    input  logic signed [COORD_WIDTH-1:0] in_second_z,
    input  logic signed [COORD_WIDTH-1:0] in_third_x,
    input  logic signed [COORD_WIDTH-1:0] in_third_y,
    input  logic signed [COORD_WIDTH-1:0] in_third_z,
    input  logic                          in_pass_start,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic [tms_pkg::IDX_W-1:0]     vertex_number,
    output logic                          tri_valid,
    output logic [tms_pkg::IDX_W-1:0]     tri_a,
    output logic [tms_pkg::IDX_W-1:0]     tri_b,
    output logic [tms_pkg::IDX_W-1:0]     tri_c,
    output logic                          last
);
    import tms_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int NW = (CW + 1 > 32) ? CW + 1 : 32;
    localparam int SW = ((CW > 32) ? CW : 32) + 1;
    localparam logic [NW-1:0] MAG_LIMIT = NW'(1) << 31;
    localparam logic [SW-1:0] NEG_MAX   = SW'(1) << (CW - 1);
    localparam logic [SW-1:0] POS_MAX   = NEG_MAX - SW'(1);
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(64'd1 << FRAC_BITS);

    logic [RADIUS_W-1:0]   radius_reg;
    logic [IDX_W-1:0]      base_reg;
    logic signed [CW-1:0]  corner_reg [9];
    logic signed [CW-1:0]  mid_reg [9];
    logic [NW-1:0]         mag_reg [3];
    logic                  neg_reg [3];
    logic [63:0]           sq_reg;
    logic [35:0]           rem_reg;
    logic [31:0]           root_reg;
    logic [63:0]           prod_reg;
    logic [31:0]           drem_reg;
    logic [31:0]           lo_reg;

    logic [1:0]            a_idx, b_idx;
    logic signed [CW:0]    sum [3];
    logic [31:0]           mag_lo;
    logic [35:0]           rem_sh, trial;
    logic [63:0]           num;
    logic [32:0]           dt;
    logic                  dge;
    logic [SW-1:0]         q_ext, q_sat;
    logic signed [CW-1:0]  q_val;
    logic [3:0]            mid_idx;
    logic [2:0]            step;

    assign status.norm_ok = (mag_reg[0] <= MAG_LIMIT) && (mag_reg[1] <= MAG_LIMIT)
                          && (mag_reg[2] <= MAG_LIMIT);

    // Edge pairs: v1+v2, v1+v3, v2+v3
    assign a_idx = (cmd.edge_sel == 2'd2) ? 2'd1 : 2'd0;
    assign b_idx = (cmd.edge_sel == 2'd0) ? 2'd1 : 2'd2;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = (CW+1)'(corner_reg[a_idx * 3 + k]) + (CW+1)'(corner_reg[b_idx * 3 + k]);
        end
    end

    assign mag_lo = mag_reg[cmd.axis][31:0];
    assign rem_sh = {rem_reg[33:0], sq_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign num    = prod_reg + 64'(root_reg >> 1);
    assign dt     = {drem_reg, lo_reg[31]};
    assign dge    = dt >= {1'b0, root_reg};

    always_comb
    begin
        q_ext = SW'(lo_reg);
        if (neg_reg[cmd.axis])
        begin
            q_sat = (q_ext > NEG_MAX) ? NEG_MAX : q_ext;
            q_val = CW'(SW'(0) - q_sat);
        end
        else
        begin
            q_sat = (q_ext > POS_MAX) ? POS_MAX : q_ext;
            q_val = CW'(q_sat);
        end
        if (root_reg == 32'd0)
        begin
            q_val = '0;
        end
    end

    assign mid_idx = 4'(cmd.edge_sel) * 4'd3 + 4'(cmd.axis);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            base_reg   <= '0;
        end
        else
        begin
            if (radius_we)
            begin
                radius_reg <= radius_wdata;
            end
            if (cmd.load && in_pass_start)
            begin
                base_reg <= '0;
            end
            else if (cmd.advance)
            begin
                base_reg <= base_reg + IDX_W'(VERTS_PER_TRI);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            corner_reg[0] <= in_first_x;
            corner_reg[1] <= in_first_y;
            corner_reg[2] <= in_first_z;
            corner_reg[3] <= in_second_x;
            corner_reg[4] <= in_second_y;
            corner_reg[5] <= in_second_z;
            corner_reg[6] <= in_third_x;
            corner_reg[7] <= in_third_y;
            corner_reg[8] <= in_third_z;
        end
        if (cmd.edge_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[k] <= sum[k][CW];
                mag_reg[k] <= NW'(sum[k][CW] ? unsigned'(-sum[k]) : unsigned'(sum[k]));
            end
            sq_reg   <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.norm_shift)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mag_reg[k] <= mag_reg[k] >> 1;
            end
        end
        if (cmd.sq_acc)
        begin
            sq_reg <= sq_reg + 64'(mag_lo) * 64'(mag_lo);
        end
        // One result bit per step: bring down two bits of the radicand
        if (cmd.root_step)
        begin
            sq_reg <= sq_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= 64'(mag_lo) * 64'(radius_reg);
        end
        // High half is below the divisor, so 32 quotient bits suffice
        if (cmd.prep)
        begin
            drem_reg <= num[63:32];
            lo_reg   <= num[31:0];
        end
        if (cmd.div_step)
        begin
            drem_reg <= dge ? 32'(dt - {1'b0, root_reg}) : dt[31:0];
            lo_reg   <= {lo_reg[30:0], dge};
        end
        if (cmd.store)
        begin
            mid_reg[mid_idx] <= q_val;
        end
    end

    assign step = cmd.step;

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            case (step)
                3'd0:
                begin
                    out_x <= corner_reg[0]; out_y <= corner_reg[1]; out_z <= corner_reg[2];
                end
                3'd1:
                begin
                    out_x <= mid_reg[0]; out_y <= mid_reg[1]; out_z <= mid_reg[2];
                end
                3'd2:
                begin
                    out_x <= mid_reg[3]; out_y <= mid_reg[4]; out_z <= mid_reg[5];
                end
                3'd3:
                begin
                    out_x <= corner_reg[3]; out_y <= corner_reg[4]; out_z <= corner_reg[5];
                end
                3'd4:
                begin
                    out_x <= mid_reg[6]; out_y <= mid_reg[7]; out_z <= mid_reg[8];
                end
                default:
                begin
                    out_x <= corner_reg[6]; out_y <= corner_reg[7]; out_z <= corner_reg[8];
                end
            endcase
            vertex_number <= base_reg + IDX_W'(step);
            tri_valid     <= (step < 3'd4);
            last          <= (step == 3'(VERTS_PER_TRI - 1));
            if (step < 3'd4)
            begin
                tri_a <= base_reg + IDX_W'(tri_corner(step, 2'd0));
                tri_b <= base_reg + IDX_W'(tri_corner(step, 2'd1));
                tri_c <= base_reg + IDX_W'(tri_corner(step, 2'd2));
            end
            else
            begin
                tri_a <= '0;
                tri_b <= '0;
                tri_c <= '0;
            end
        end
    end

endmodule
